// ===== rtl/ffra_pkg.sv =====
// Package: shared types and constants of the first-fit range allocator.
package ffra_pkg;

    localparam int MaxHoles   = 64;
    localparam int HoleIdxW   = $clog2(MaxHoles);
    localparam int HoleCntW   = $clog2(MaxHoles + 1);
    localparam int FirstW     = 24;
    localparam int CountW     = 25;
    localparam int SumW       = 26;
    localparam logic [SumW-1:0] SpaceUnits = 26'd16777216;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MRGR, S_MRGL, S_TOP, S_OUT
    } t_state;

    // one hole entry
    typedef struct packed {
        logic [FirstW-1:0] first;
        logic [CountW-1:0] len;
    } t_hole;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CC_HOLD,     // keep contents
        CC_CLEAR,    // keep contents; the top level drops all holes by zeroing the count
        CC_SHRINK,   // selected cell: first += n, len -= n
        CC_REMOVE,   // cells at/after sel take right neighbor
        CC_INSERT,   // cells after sel take left neighbor; sel loads new hole
        CC_MERGE     // selected cell: len += n; cells after sel take right neighbor
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [HoleIdxW-1:0] sel;
        t_hole              hole;
        logic [CountW-1:0]  n;
        logic [CountW-1:0]  need;   // size for the fit compare
        logic [FirstW-1:0]  key;    // start for the insert-position compare
    } t_ctl;

endpackage

// ===== rtl/ffra_cell.sv =====
// Hole cell: holds one hole, compares it against the request, shifts with neighbors.
module ffra_cell (
    input  logic                 i_clk,
    input  ffra_pkg::t_ctl       i_ctl,
    input  logic [ffra_pkg::HoleIdxW-1:0] i_idx,
    input  ffra_pkg::t_hole      i_left,
    input  ffra_pkg::t_hole      i_right,
    output ffra_pkg::t_hole      o_hole,
    output logic                 o_fit,
    output logic                 o_below
);
    import ffra_pkg::*;

    t_hole r_hole;
    t_hole n_hole;

    // next contents from the broadcast command
    always_comb begin
        n_hole = r_hole;
        unique case (i_ctl.cmd)
            CC_HOLD, CC_CLEAR: n_hole = r_hole;
            CC_SHRINK: if (i_idx == i_ctl.sel) begin
                n_hole.first = r_hole.first + i_ctl.n[FirstW-1:0];
                n_hole.len   = r_hole.len - i_ctl.n;
            end
            CC_REMOVE: if (i_idx >= i_ctl.sel) n_hole = i_right;
            CC_INSERT: begin
                if (i_idx == i_ctl.sel)     n_hole = i_ctl.hole;
                else if (i_idx > i_ctl.sel) n_hole = i_left;
            end
            CC_MERGE: begin
                if (i_idx == i_ctl.sel)     n_hole.len = r_hole.len + i_ctl.n;
                else if (i_idx > i_ctl.sel) n_hole = i_right;
            end
            default: n_hole = r_hole;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hole <= n_hole;
    end

    assign o_hole  = r_hole;
    assign o_fit   = (r_hole.len >= i_ctl.need);
    assign o_below = (r_hole.first < i_ctl.key);
endmodule

// ===== rtl/ffra_chain.sv =====
// Row of hole cells with per-entry valid mask and first-match pick.
module ffra_chain (
    input  logic                          i_clk,
    input  ffra_pkg::t_ctl                i_ctl,
    input  logic [ffra_pkg::HoleCntW-1:0] i_count,
    output ffra_pkg::t_hole               o_holes [ffra_pkg::MaxHoles],
    output logic                          o_fit_any,
    output logic [ffra_pkg::HoleIdxW-1:0] o_fit_idx,
    output logic [ffra_pkg::HoleCntW-1:0] o_pos
);
    import ffra_pkg::*;

    logic [MaxHoles-1:0] w_fit;
    logic [MaxHoles-1:0] w_below;
    t_hole               w_zero;

    assign w_zero = '0;

    genvar g;
    generate
        for (g = 0; g < MaxHoles; g++) begin : g_cell
            ffra_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_idx   (HoleIdxW'(g)),
                .i_left  ((g == 0) ? w_zero : o_holes[(g == 0) ? 0 : g - 1]),
                .i_right ((g == MaxHoles - 1) ? w_zero
                          : o_holes[(g == MaxHoles - 1) ? g : g + 1]),
                .o_hole  (o_holes[g]),
                .o_fit   (w_fit[g]),
                .o_below (w_below[g])
            );
        end
    endgenerate

    // lowest valid fitting cell; insert position = lowest valid cell not below key
    always_comb begin
        o_fit_any = 1'b0;
        o_fit_idx = '0;
        o_pos     = i_count;
        for (int k = MaxHoles - 1; k >= 0; k--) begin
            if (w_fit[k] && (HoleCntW'(k) < i_count)) begin
                o_fit_any = 1'b1;
                o_fit_idx = HoleIdxW'(k);
            end
            if (!w_below[k] && (HoleCntW'(k) < i_count)) o_pos = HoleCntW'(k);
        end
    end
endmodule

// ===== rtl/first_fit_range_allocator_unit.sv =====
// Top level: first-fit range allocator with a chain of hole cells and a sequencer.
//
//  channel | dir | tdata fields (low bit first)               | tuser
//  s_axis  | in  | op[1:0] req_first[25:2] req_count[50:26]    | -
//  m_axis  | out | status[1:0] result_first[25:2]             | -
//          |     | result_count[50:26] used_top[75:51]        |
//          |     | free_units[100:76]                         |
//
// Allocate, clear, rejected and unknown ops go through the execute state only;
// the result is then offered, and the next beat is taken once it is accepted
// and the sequencer is idle again. A free that inserts a hole adds the right
// merge, left merge and top check states before the result is offered.
// A result held back by m_axis_tready also holds back the next input beat.
// i_rst_n clears the count, top and sum; hole contents are left as they are.
module first_fit_range_allocator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // op, req_first, req_count
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // status, result_first, result_count,
                                          // used_top, free_units
);
    import ffra_pkg::*;

    t_state r_state, n_state;
    logic [HoleCntW-1:0] r_cnt, n_cnt;
    logic [CountW-1:0]   r_top, n_top, r_sum, n_sum;
    logic [1:0]          r_op;
    logic [FirstW-1:0]   r_first, r_rf, n_rf;
    logic [CountW-1:0]   r_reqc, r_rc, n_rc;
    logic [HoleIdxW-1:0] r_pos, n_pos;
    logic [1:0]          r_st, n_st;
    logic                r_ov;

    t_ctl                w_ctl;
    t_hole               w_holes [MaxHoles];
    logic                w_fit_any;
    logic [HoleIdxW-1:0] w_fit_idx;
    logic [HoleCntW-1:0] w_pos;
    logic [HoleIdxW-1:0] w_ra, w_rb;
    t_hole               w_rd_a, w_rd_b;
    logic [SumW-1:0]     w_a_end;
    logic                w_do_ins;

    ffra_chain u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_count   (r_cnt),
        .o_holes   (w_holes),
        .o_fit_any (w_fit_any),
        .o_fit_idx (w_fit_idx),
        .o_pos     (w_pos)
    );

    // two read ports into the chain, addressed by state
    always_comb begin
        w_ra = r_pos;
        w_rb = r_pos + HoleIdxW'(1);
        unique case (r_state)
            S_EXEC: w_ra = w_fit_idx;
            S_MRGL: begin
                w_ra = r_pos - HoleIdxW'(1);
                w_rb = r_pos;
            end
            S_TOP:  w_ra = HoleIdxW'(r_cnt - HoleCntW'(1));
            default: ;
        endcase
    end

    assign w_rd_a  = w_holes[w_ra];
    assign w_rd_b  = w_holes[w_rb];
    assign w_a_end = SumW'(w_rd_a.first) + SumW'(w_rd_a.len);

    // free that lands in the table
    assign w_do_ins = (r_op == OP_FREE) && (r_reqc != '0) && !r_ov
                      && (r_cnt != HoleCntW'(MaxHoles));

    assign s_axis_tready = (r_state == S_IDLE);

    // input capture and output holding registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op    <= s_axis_tdata[1:0];
            r_first <= s_axis_tdata[25:2];
            r_reqc  <= s_axis_tdata[50:26];
            r_ov    <= (SumW'(s_axis_tdata[25:2]) + SumW'(s_axis_tdata[50:26]))
                       > SpaceUnits;
        end
        r_rf  <= n_rf;
        r_rc  <= n_rc;
        r_st  <= n_st;
        r_pos <= n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_top   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_top   <= n_top;
            r_sum   <= n_sum;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_EXEC;
            S_EXEC: begin
                if (w_do_ins) n_state = S_MRGR;
                else n_state = S_OUT;
            end
            S_MRGR: n_state = S_MRGL;
            S_MRGL: n_state = S_TOP;
            S_TOP:  n_state = S_OUT;
            S_OUT:  if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control and cell commands
    always_comb begin
        n_cnt = r_cnt; n_top = r_top; n_sum = r_sum;
        n_rf = r_rf; n_rc = r_rc; n_st = r_st; n_pos = r_pos;
        w_ctl = '0;
        w_ctl.cmd  = CC_HOLD;
        w_ctl.need = r_reqc;
        w_ctl.key  = r_first;
        unique case (r_state)
            S_IDLE: begin
                n_rf = '0; n_rc = '0; n_st = ST_OK;
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ALLOC: begin
                        if (r_reqc == '0) n_st = ST_IGNORED;
                        else if (w_fit_any) begin
                            n_rf = w_rd_a.first;
                            n_rc = r_reqc;
                            w_ctl.sel = w_fit_idx;
                            w_ctl.n   = r_reqc;
                            if (w_rd_a.len == r_reqc) begin
                                w_ctl.cmd = CC_REMOVE;
                                n_cnt = r_cnt - HoleCntW'(1);
                            end else w_ctl.cmd = CC_SHRINK;
                            n_sum = r_sum - r_reqc;
                        end else if ((SumW'(r_top) + SumW'(r_reqc)) > SpaceUnits)
                            n_st = ST_NOSPACE;
                        else begin
                            n_rf = r_top[FirstW-1:0];
                            n_rc = r_reqc;
                            n_top = r_top + r_reqc;
                        end
                    end
                    OP_FREE: begin
                        if (r_reqc == '0) n_st = ST_IGNORED;
                        else if (r_ov) n_st = ST_NOSPACE;
                        else if (r_cnt == HoleCntW'(MaxHoles)) n_st = ST_FULL;
                        else begin
                            w_ctl.cmd = CC_INSERT;
                            w_ctl.sel = HoleIdxW'(w_pos);
                            w_ctl.hole.first = r_first;
                            w_ctl.hole.len   = r_reqc;
                            n_pos = HoleIdxW'(w_pos);
                            n_cnt = r_cnt + HoleCntW'(1);
                            n_sum = r_sum + r_reqc;
                        end
                    end
                    OP_CLEAR: begin
                        w_ctl.cmd = CC_CLEAR;
                        n_cnt = '0; n_top = '0; n_sum = '0;
                    end
                    default: n_st = ST_IGNORED;
                endcase
            end
            S_MRGR: begin
                // new hole ends where its right neighbor starts
                if ((HoleCntW'(r_pos) + HoleCntW'(1) < r_cnt)
                    && (w_a_end == SumW'(w_rd_b.first))) begin
                    w_ctl.cmd = CC_MERGE;
                    w_ctl.sel = r_pos;
                    w_ctl.n   = w_rd_b.len;
                    n_cnt = r_cnt - HoleCntW'(1);
                end
            end
            S_MRGL: begin
                // left neighbor ends where the new hole starts
                if ((r_pos != '0) && (w_a_end == SumW'(w_rd_b.first))) begin
                    w_ctl.cmd = CC_MERGE;
                    w_ctl.sel = r_pos - HoleIdxW'(1);
                    w_ctl.n   = w_rd_b.len;
                    n_cnt = r_cnt - HoleCntW'(1);
                end
            end
            S_TOP: begin
                // last hole reaching the top lowers the top
                if ((r_cnt != '0) && (w_a_end == SumW'(r_top))) begin
                    n_top = CountW'(w_rd_a.first);
                    n_sum = r_sum - w_rd_a.len;
                    n_cnt = r_cnt - HoleCntW'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {3'b0, r_sum, r_top, r_rc, r_rf, r_st};

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("ready while busy");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= HoleCntW'(MaxHoles))
        else $error("count overflow");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while waiting");
endmodule

// ===== tb/first_fit_range_allocator_unit_tb.sv =====
// First-fit allocator testbench: directed and random streams checked against a behavioral hole table.
`timescale 1ns / 1ps

module first_fit_range_allocator_unit_tb;
    import ffra_pkg::*;

    localparam int    WatchdogLimit = 20000;
    localparam longint Space        = 64'd16777216;

    // one request beat
    typedef struct {
        t_op         op;
        logic [23:0] first;
        logic [24:0] count;
    } t_req;

    // one result beat
    typedef struct {
        t_status     status;
        logic [23:0] rfirst;
        logic [24:0] rcount;
        logic [24:0] top;
        logic [24:0] free;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;

    first_fit_range_allocator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // allocator shadow state
    longint hole_start[MaxHoles+1];
    longint hole_size[MaxHoles+1];
    int     nholes = 0;
    longint top_units = 0;
    longint free_total = 0;

    t_req   pending_reqs[$];
    t_res   expected_results[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     stim_done = 1'b0;
    int     send_gap = 0;
    int     recv_gap = 0;

    // input beat taken at the last rising edge
    logic   in_taken = 1'b0;

    // ranges handed out, for well-formed frees
    longint granted_first[$];
    longint granted_len[$];

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void drop_hole(input int idx);
        for (int k = idx; k + 1 < nholes; k++) begin
            hole_start[k] = hole_start[k+1];
            hole_size[k]  = hole_size[k+1];
        end
        nholes--;
    endfunction

    // apply one request to the shadow table and return the expected result
    function automatic t_res allocate_step(input t_req r);
        t_res   res;
        longint cnt;
        longint rf;
        int     pos;
        bit     done;
        res = '{ST_OK, '0, '0, '0, '0};
        cnt = longint'(r.count);
        rf = longint'(r.first);
        done = 1'b0;
        case (r.op)
            OP_ALLOC: begin
                if (cnt == 0) begin
                    res.status = ST_IGNORED;
                end else begin
                    for (int i = 0; i < nholes && !done; i++) begin
                        if (hole_size[i] >= cnt) begin
                            res.rfirst = hole_start[i][23:0];
                            res.rcount = cnt[24:0];
                            if (hole_size[i] == cnt) drop_hole(i);
                            else begin
                                hole_start[i] += cnt;
                                hole_size[i]  -= cnt;
                            end
                            free_total = (free_total - cnt) & 64'h1FFFFFF;
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (top_units + cnt > Space) res.status = ST_NOSPACE;
                        else begin
                            res.rfirst = top_units[23:0];
                            res.rcount = cnt[24:0];
                            top_units += cnt;
                        end
                    end
                end
            end
            OP_FREE: begin
                if (cnt == 0) res.status = ST_IGNORED;
                else if (rf + cnt > Space) res.status = ST_NOSPACE;
                else if (nholes >= MaxHoles) res.status = ST_FULL;
                else begin
                    pos = 0;
                    while (pos < nholes && hole_start[pos] < rf) pos++;
                    for (int k = nholes; k > pos; k--) begin
                        hole_start[k] = hole_start[k-1];
                        hole_size[k]  = hole_size[k-1];
                    end
                    hole_start[pos] = rf;
                    hole_size[pos]  = cnt;
                    nholes++;
                    free_total = (free_total + cnt) & 64'h1FFFFFF;
                    // right neighbor, then left neighbor
                    if (pos + 1 < nholes
                        && hole_start[pos] + hole_size[pos] == hole_start[pos+1]) begin
                        hole_size[pos] += hole_size[pos+1];
                        drop_hole(pos + 1);
                    end
                    if (pos > 0 && hole_start[pos-1] + hole_size[pos-1] == hole_start[pos]) begin
                        hole_size[pos-1] += hole_size[pos];
                        drop_hole(pos);
                    end
                    // last hole touching the top lowers the top
                    if (nholes > 0 &&
                        hole_start[nholes-1] + hole_size[nholes-1] == top_units) begin
                        top_units  = hole_start[nholes-1];
                        free_total = (free_total - hole_size[nholes-1]) & 64'h1FFFFFF;
                        nholes--;
                    end
                end
            end
            OP_CLEAR: begin
                nholes = 0;
                top_units = 0;
                free_total = 0;
            end
            default: res.status = ST_IGNORED;
        endcase
        res.top  = top_units[24:0];
        res.free = free_total[24:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic t_req mk(input t_op op, input longint first, input longint count);
        t_req r;
        r.op = op;
        r.first = first[23:0];
        r.count = count[24:0];
        return r;
    endfunction

    // random count, mostly small
    function automatic longint rnd_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 3) return 0;
        if (p < 80) return $urandom_range(1, 64);
        if (p < 95) return $urandom_range(1, 1 << 20);
        return $urandom_range(0, 1 << 25);
    endfunction

    // stimulus generation
    initial begin
        longint lens[$];
        int     idx;
        int     p;
        // directed part
        pending_reqs.push_back(mk(OP_ALLOC, 0, 0));
        pending_reqs.push_back(mk(OP_FREE, 5, 0));
        pending_reqs.push_back(mk(OP_NONE, 24'hFFFFFF, 25'h1FFFFFF));
        pending_reqs.push_back(mk(OP_ALLOC, 24'hFFFFFF, Space));
        pending_reqs.push_back(mk(OP_ALLOC, 0, 1));
        pending_reqs.push_back(mk(OP_FREE, 24'hFFFFFF, 2));
        pending_reqs.push_back(mk(OP_FREE, 0, 25'h1FFFFFF));
        pending_reqs.push_back(mk(OP_CLEAR, 0, 0));
        pending_reqs.push_back(mk(OP_ALLOC, 0, 100));
        pending_reqs.push_back(mk(OP_FREE, 10, 10));
        pending_reqs.push_back(mk(OP_FREE, 30, 10));
        pending_reqs.push_back(mk(OP_FREE, 20, 10));
        pending_reqs.push_back(mk(OP_ALLOC, 0, 5));
        pending_reqs.push_back(mk(OP_ALLOC, 0, 25));
        pending_reqs.push_back(mk(OP_FREE, 50, 50));
        pending_reqs.push_back(mk(OP_FREE, 0, 50));
        pending_reqs.push_back(mk(OP_CLEAR, 24'hFFFFFF, 25'h1FFFFFF));
        pending_reqs.push_back(mk(OP_ALLOC, 0, 300));
        for (int i = 0; i < 66; i++) pending_reqs.push_back(mk(OP_FREE, 2 * i, 1));
        pending_reqs.push_back(mk(OP_FREE, 1, 1));
        pending_reqs.push_back(mk(OP_CLEAR, 0, 0));
        pending_reqs.push_back(mk(OP_ALLOC, 0, Space - 1));
        pending_reqs.push_back(mk(OP_ALLOC, 0, 2));
        pending_reqs.push_back(mk(OP_FREE, 24'hFFFFFF, 1));
        pending_reqs.push_back(mk(OP_CLEAR, 0, 0));
        // random part: allocate, then free remembered ranges mostly
        for (int n = 0; n < 1300; n++) begin
            p = $urandom_range(0, 99);
            if (p < 40) begin
                longint c;
                c = rnd_count();
                pending_reqs.push_back(mk(OP_ALLOC, $urandom, c));
                lens.push_back(c);
            end else if (p < 80 && lens.size() > 0) begin
                // free a granted range; the driver picks it and its start when the beat goes out
                idx = $urandom_range(0, lens.size() - 1);
                pending_reqs.push_back(mk(OP_FREE, -1, lens[idx]));
                lens.delete(idx);
            end else if (p < 95) begin
                pending_reqs.push_back(mk(OP_FREE, $urandom_range(0, 4000),
                                          $urandom_range(0, 200)));
            end else if (p < 98) begin
                pending_reqs.push_back(mk(OP_CLEAR, $urandom, $urandom));
            end else begin
                pending_reqs.push_back(mk(OP_NONE, $urandom, $urandom));
            end
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        t_req   r;
        int     g;
        int     part;
        longint half;
        if (i_rst_n) begin
            // a new beat may go out when nothing is offered or the last one was taken
            if ((!s_axis_tvalid || in_taken) && !stim_done) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    stim_done = 1'b1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    r = pending_reqs.pop_front();
                    if (r.op == OP_FREE && r.first == 24'hFFFFFF && granted_first.size() > 0
                        && $urandom_range(0, 3) != 0) begin
                        g = $urandom_range(0, granted_first.size() - 1);
                        // free whole range or its front half
                        part = $urandom_range(0, 2);
                        r.first = granted_first[g][23:0];
                        r.count = granted_len[g][24:0];
                        if (part == 1 && granted_len[g] > 1) begin
                            half = granted_len[g] / 2;
                            r.count = half[24:0];
                        end
                        granted_first.delete(g);
                        granted_len.delete(g);
                    end
                    s_axis_tdata  <= {5'b0, r.count, r.first, r.op};
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 9) == 0) recv_gap = pick_gap();
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_req r;
        t_res e;
        t_res g;
        logic in_acc;
        logic out_acc;
        in_acc  = s_axis_tvalid && s_axis_tready;
        out_acc = m_axis_tvalid && m_axis_tready;
        in_taken <= in_acc;
        if (i_rst_n) begin
            if (in_acc) begin
                r.op    = t_op'(s_axis_tdata[1:0]);
                r.first = s_axis_tdata[25:2];
                r.count = s_axis_tdata[50:26];
                e = allocate_step(r);
                if (r.op == OP_ALLOC && e.status == ST_OK) begin
                    granted_first.push_back(longint'(e.rfirst));
                    granted_len.push_back(longint'(e.rcount));
                end
                if (r.op == OP_CLEAR) begin
                    granted_first.delete();
                    granted_len.delete();
                end
                expected_results.push_back(e);
            end
            if (out_acc) begin
                g.status = t_status'(m_axis_tdata[1:0]);
                g.rfirst = m_axis_tdata[25:2];
                g.rcount = m_axis_tdata[50:26];
                g.top    = m_axis_tdata[75:51];
                g.free   = m_axis_tdata[100:76];
                if (expected_results.size() == 0) begin
                    report("unexpected beat", g.status, -1);
                end else begin
                    e = expected_results.pop_front();
                    if (g.status != e.status) report("status", g.status, e.status);
                    if (g.rfirst != e.rfirst) report("result_first", g.rfirst, e.rfirst);
                    if (g.rcount != e.rcount) report("result_count", g.rcount, e.rcount);
                    if (g.top != e.top) report("used_top", g.top, e.top);
                    if (g.free != e.free) report("free_units", g.free, e.free);
                end
            end
            idle_cycles <= (in_acc || out_acc) ? 0 : idle_cycles + 1;
        end
    end

    // end of run and watchdog
    initial begin
        wait (i_rst_n);
        while (!(stim_done && expected_results.size() == 0) && idle_cycles < WatchdogLimit)
            @(posedge i_clk);
        if (idle_cycles >= WatchdogLimit) begin
            $display("** first_fit_range_allocator_unit: FAILED **");
            $finish;
        end else begin
            repeat (20) @(posedge i_clk);
            if (errors == 0 && expected_results.size() == 0) begin
                $display("** first_fit_range_allocator_unit: PASSED **");
            end else begin
                $display("** first_fit_range_allocator_unit: FAILED **");
            end
            $finish;
        end
    end

endmodule
